// ===== design/brsc_pkg.sv =====
// Shared types, codes and defaults of the banker's request safety check unit.
package brsc_pkg;

  localparam int unsigned DEF_MAX_PROCESSES = 16;
  localparam int unsigned DEF_MAX_RESOURCES = 16;
  localparam int unsigned DEF_COUNT_BITS    = 8;

  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 8;
  localparam int unsigned CFG_REG_BITS  = 5;
  localparam logic [CFG_REG_BITS-1:0] CFG_REG_RESET = 5'd16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PROCESS_COUNT  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RESOURCE_COUNT = 4'd1;

  typedef enum logic [2:0] {
    CMD_SET_AVAIL  = 3'd0,
    CMD_SET_MAX    = 3'd1,
    CMD_SET_ALLOC  = 3'd2,
    CMD_STAGE      = 3'd3,
    CMD_EVAL       = 3'd4,
    CMD_READ_AVAIL = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    RS_DONE        = 2'd0,
    RS_NOT_ALLOWED = 2'd1,
    RS_SAFE        = 2'd2,
    RS_UNSAFE      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRANT_RD,
    S_GRANT_AP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_APPLY,
    S_RESULT
  } fsm_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] proc;
    logic [3:0] res;
    logic [7:0] value;
    logic       commit;
  } in_item_t;

  typedef struct packed {
    logic load;
    logic grant_rd;
    logic grant_ap;
    logic scan_rd;
    logic scan_cmp;
    logic apply;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic eval_go;
    logic idx_end;
    logic idx_fin;
    logic fit;
    logic last_round;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/brsc_if.sv =====
// Handshake channel interfaces: input items, result items and configuration writes.
interface brsc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [3:0] proc;
  logic [3:0] res;
  logic [7:0] value;
  logic       commit;
  modport source (output valid, cmd, proc, res, value, commit, input ready);
  modport sink   (input valid, cmd, proc, res, value, commit, output ready);
endinterface

interface brsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] read_value;
  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

interface brsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/brsc_ctrl.sv =====
// Controller state machine sequencing table loads, the grant and the safety walk.
module brsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  brsc_pkg::dp_sts_t   sts_i,
  output brsc_pkg::ctrl_cmd_t cmd_o
);
  import brsc_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.eval_go ? S_GRANT_RD : S_RESULT;
        end
      end
      S_GRANT_RD: state_d = S_GRANT_AP;
      S_GRANT_AP: state_d = S_SCAN_RD;
      S_SCAN_RD: begin
        if (sts_i.idx_end) begin
          state_d = S_APPLY;
        end else if (!sts_i.idx_fin) begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: state_d = (sts_i.fit && sts_i.last_round) ? S_APPLY : S_SCAN_RD;
      S_APPLY:    state_d = S_RESULT;
      S_RESULT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_GRANT_RD: cmd_o.grant_rd = 1'b1;
      S_GRANT_AP: cmd_o.grant_ap = 1'b1;
      S_SCAN_RD:  cmd_o.scan_rd  = 1'b1;
      S_SCAN_CMP: cmd_o.scan_cmp = 1'b1;
      S_APPLY:    cmd_o.apply    = 1'b1;
      S_RESULT:   cmd_o.out_load = sts_i.out_free;
      default:    cmd_o          = '0;
    endcase
  end

endmodule

// ===== design/brsc_dp.sv =====
// Datapath: tables, staged demand, work vector, finished flags and result register.
module brsc_dp #(
  parameter int unsigned MAX_PROCESSES = brsc_pkg::DEF_MAX_PROCESSES,
  parameter int unsigned MAX_RESOURCES = brsc_pkg::DEF_MAX_RESOURCES,
  parameter int unsigned COUNT_BITS    = brsc_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  brsc_pkg::in_item_t                  item_i,
  input  logic                                cfg_we_i,
  input  logic [brsc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [brsc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  brsc_pkg::ctrl_cmd_t                 cmd_i,
  output brsc_pkg::dp_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          out_status_o,
  output logic [7:0]                          out_read_value_o
);
  import brsc_pkg::*;

  localparam int unsigned P    = MAX_PROCESSES;
  localparam int unsigned R    = MAX_RESOURCES;
  localparam int unsigned CB   = COUNT_BITS;
  localparam int unsigned WB   = COUNT_BITS + 4;
  localparam int unsigned PIW  = $clog2(P);
  localparam int unsigned RIW  = (R > 1) ? $clog2(R) : 1;
  localparam int unsigned PCW  = $clog2(P + 1);
  localparam int unsigned RCW  = $clog2(R + 1);
  localparam int unsigned CMAX = (1 << CB) - 1;
  localparam logic [WB-1:0] WMAX = {WB{1'b1}};

  typedef logic [R-1:0][CB-1:0] row_t;

  logic [CFG_REG_BITS-1:0] pcfg_q, rcfg_q;
  logic [PCW-1:0]          pc;
  logic [RCW-1:0]          rc;
  logic [R-1:0]            act;

  logic [R-1:0][CB-1:0]    avail_q;
  logic [R-1:0][CB-1:0]    staged_q;
  logic [R-1:0][WB-1:0]    work_q;
  logic [P-1:0]            fin_q;
  logic [PCW-1:0]          idx_q, rounds_q;
  logic [PIW-1:0]          idx_w, p_q;
  logic                    commit_q;
  row_t                    grant_q;

  row_t                    max_mem   [P];
  row_t                    alloc_mem [P];
  row_t                    max_rd_q, alloc_rd_q;

  logic                    rd_en;
  logic [PIW-1:0]          rd_addr;
  logic                    ld_max_we, ld_alloc_we, ap_alloc_we;

  logic [CB-1:0]           vsat;
  logic                    p_tab_ok, r_ok, p_eval_ok, demand_ok;
  logic [PIW-1:0]          in_p;
  logic [RIW-1:0]          in_r;
  row_t                    cmp_alloc;
  logic                    fit;

  logic [1:0]              res_status_q;
  logic [7:0]              res_rv_q;
  logic                    out_valid_q;
  logic [1:0]              out_status_q;
  logic [7:0]              out_rv_q;

  assign pc = (32'(pcfg_q) > P) ? PCW'(P) : PCW'(pcfg_q);
  assign rc = (32'(rcfg_q) > R) ? RCW'(R) : RCW'(rcfg_q);

  always_comb begin
    for (int j = 0; j < R; j++) begin
      act[j] = (32'(j) < 32'(rc));
    end
  end

  assign vsat      = (32'(item_i.value) > CMAX) ? CB'(CMAX) : CB'(item_i.value);
  assign p_tab_ok  = 32'(item_i.proc) < P;
  assign r_ok      = 32'(item_i.res) < R;
  assign p_eval_ok = 32'(item_i.proc) < 32'(pc);
  assign in_p      = PIW'(item_i.proc);
  assign in_r      = RIW'(item_i.res);
  assign idx_w     = idx_q[PIW-1:0];

  always_comb begin
    demand_ok = 1'b1;
    for (int j = 0; j < R; j++) begin
      if (act[j] && (staged_q[j] > avail_q[j])) begin
        demand_ok = 1'b0;
      end
    end
  end

  assign cmp_alloc = (idx_w == p_q) ? grant_q : alloc_rd_q;

  always_comb begin
    fit = 1'b1;
    for (int j = 0; j < R; j++) begin
      if (act[j] && (max_rd_q[j] > cmp_alloc[j]) &&
          (WB'(max_rd_q[j] - cmp_alloc[j]) > work_q[j])) begin
        fit = 1'b0;
      end
    end
  end

  assign sts_o.eval_go    = (item_i.cmd == CMD_EVAL) && p_eval_ok && demand_ok;
  assign sts_o.idx_end    = (idx_q == pc);
  assign sts_o.idx_fin    = fin_q[idx_w];
  assign sts_o.fit        = fit;
  assign sts_o.last_round = (PCW'(rounds_q + 1'b1) == pc);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcfg_q <= CFG_REG_RESET;
      rcfg_q <= CFG_REG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROCESS_COUNT:  pcfg_q <= cfg_data_i[CFG_REG_BITS-1:0];
        CFG_RESOURCE_COUNT: rcfg_q <= cfg_data_i[CFG_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ld_max_we   = cmd_i.load && (item_i.cmd == CMD_SET_MAX) && p_tab_ok && r_ok;
  assign ld_alloc_we = cmd_i.load && (item_i.cmd == CMD_SET_ALLOC) && p_tab_ok && r_ok;
  assign ap_alloc_we = cmd_i.apply && commit_q;
  assign rd_en       = cmd_i.grant_rd ||
                       (cmd_i.scan_rd && !sts_o.idx_end && !sts_o.idx_fin);
  assign rd_addr     = cmd_i.grant_rd ? p_q : idx_w;

  always_ff @(posedge clk_i) begin
    if (ld_max_we) begin
      max_mem[in_p][in_r] <= vsat;
    end
    if (ld_alloc_we) begin
      alloc_mem[in_p][in_r] <= vsat;
    end else if (ap_alloc_we) begin
      alloc_mem[p_q] <= grant_q;
    end
    if (rd_en) begin
      max_rd_q   <= max_mem[rd_addr];
      alloc_rd_q <= alloc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q      <= in_p;
      commit_q <= item_i.commit;
      res_rv_q <= '0;
      if (item_i.cmd == CMD_SET_AVAIL && r_ok) begin
        avail_q[in_r] <= vsat;
      end
      if (item_i.cmd == CMD_READ_AVAIL && r_ok) begin
        res_rv_q <= 8'(avail_q[in_r]);
      end
      res_status_q <= (item_i.cmd == CMD_EVAL) ? RS_NOT_ALLOWED : RS_DONE;
    end
    if (cmd_i.grant_ap) begin
      for (int j = 0; j < R; j++) begin
        if (act[j]) begin
          grant_q[j] <= ((32'(alloc_rd_q[j]) + 32'(staged_q[j])) > CMAX) ?
                        CB'(CMAX) : CB'(alloc_rd_q[j] + staged_q[j]);
        end else begin
          grant_q[j] <= alloc_rd_q[j];
        end
      end
    end
    if (cmd_i.apply) begin
      res_status_q <= (rounds_q == pc) ? RS_SAFE : RS_UNSAFE;
      if (commit_q) begin
        for (int j = 0; j < R; j++) begin
          if (act[j]) begin
            avail_q[j] <= avail_q[j] - staged_q[j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_q <= '0;
      work_q   <= '0;
      fin_q    <= '0;
      idx_q    <= '0;
      rounds_q <= '0;
    end else begin
      if (cmd_i.load && item_i.cmd == CMD_STAGE && r_ok) begin
        staged_q[in_r] <= vsat;
      end
      if (cmd_i.grant_ap) begin
        fin_q    <= '0;
        idx_q    <= '0;
        rounds_q <= '0;
        for (int j = 0; j < R; j++) begin
          if (act[j]) begin
            work_q[j] <= WB'(avail_q[j] - staged_q[j]);
          end
        end
      end
      if (cmd_i.scan_rd && !sts_o.idx_end && sts_o.idx_fin) begin
        idx_q <= PCW'(idx_q + 1'b1);
      end
      if (cmd_i.scan_cmp) begin
        if (fit) begin
          fin_q[idx_w] <= 1'b1;
          idx_q        <= '0;
          rounds_q     <= PCW'(rounds_q + 1'b1);
          for (int j = 0; j < R; j++) begin
            if (act[j]) begin
              work_q[j] <= ((32'(work_q[j]) + 32'(cmp_alloc[j])) > 32'(WMAX)) ?
                           WMAX : WB'(work_q[j] + cmp_alloc[j]);
            end
          end
        end else begin
          idx_q <= PCW'(idx_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_rv_q     <= res_rv_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_read_value_o = out_rv_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (idx_q <= pc))
    else $error("scan index beyond process count");

  a_cmp_unfinished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_cmp |-> !fin_q[idx_w])
    else $error("finished process compared again");

  a_rounds_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> (rounds_q <= pc))
    else $error("walk rounds beyond process count");

  a_one_alloc_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ld_alloc_we && ap_alloc_we))
    else $error("two allocation writes in one cycle");

endmodule

// ===== design/bankers_request_safety_check_unit.sv =====
// Top level of the banker's request safety check unit.
//
//   channel  modport  carries                              transaction when
//   in_if    sink     cmd, proc, res, value, commit        valid && ready
//   out_if   source   status, read_value                   valid && ready
//   cfg_if   sink     index, data (5-bit count registers)  valid && ready
//
// Load, stage, read and rejected evaluate items go from idle straight to the result state.
// Evaluate runs the walk one process row at a time from the table memories:
// after the grant read and update, each unfinished process is read and then
// compared, finished ones are skipped, and apply and result follow the walk.
// Input is taken again once the result sits in the output register.
// Reset clears control, staged demand and work; tables stay undefined.
module bankers_request_safety_check_unit #(
  parameter int unsigned MAX_PROCESSES = brsc_pkg::DEF_MAX_PROCESSES,
  parameter int unsigned MAX_RESOURCES = brsc_pkg::DEF_MAX_RESOURCES,
  parameter int unsigned COUNT_BITS    = brsc_pkg::DEF_COUNT_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  brsc_in_if.sink  in_if,
  brsc_out_if.source out_if,
  brsc_cfg_if.sink cfg_if
);
  import brsc_pkg::*;

  in_item_t  item;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  assign item.cmd    = in_if.cmd;
  assign item.proc   = in_if.proc;
  assign item.res    = in_if.res;
  assign item.value  = in_if.value;
  assign item.commit = in_if.commit;
  assign in_if.ready = in_ready;
  assign cfg_if.ready = 1'b1;

  brsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brsc_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .cfg_we_i         (cfg_if.valid),
    .cfg_idx_i        (cfg_if.index),
    .cfg_data_i       (cfg_if.data),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .out_status_o     (out_if.status),
    .out_read_value_o (out_if.read_value)
  );

endmodule
